FILE: hw/rtl/slc_pkg.sv
// Package for the sorted list with cursor.
// Operation and status codes, cell interface structs, default depth.
// No dependencies.
package slc_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [2:0] {
        KIND_READ,
        KIND_INSERT,
        KIND_REMOVE,
        KIND_ADVANCE,
        KIND_RETREAT,
        KIND_FIRST,
        KIND_LAST,
        KIND_CLEAR
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_MARKER,
        ST_NO_ADVANCE,
        ST_NO_RETREAT,
        ST_FULL
    } status_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic                    apply;
        kind_t                   kind;
        logic signed [VAL_W-1:0] value;
        logic                    empty;
    } op_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic signed [VAL_W-1:0] entry;
        logic                    valid;
        logic                    flag;   // empty, or holds a value greater than the insert value
        logic                    curs;   // cursor position <= this cell's position
    } nbr_t;

endpackage

FILE: hw/rtl/slc_cell.sv
// One cell of the list: an entry, its valid bit and one cursor thermometer bit.
// Depends on slc_pkg.
module slc_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  slc_pkg::op_t  op,
    input  slc_pkg::nbr_t left,
    input  slc_pkg::nbr_t right,
    output slc_pkg::nbr_t self
);

    logic signed [slc_pkg::VAL_W-1:0] entry_reg;
    logic signed [slc_pkg::VAL_W-1:0] entry_next;
    logic                             valid_reg;
    logic                             valid_next;
    logic                             curs_reg;
    logic                             curs_next;
    logic                             flag;

    assign flag = !valid_reg || (op.value < entry_reg);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        curs_next  = curs_reg;
        if (op.apply)
        begin
            case (op.kind)
                slc_pkg::KIND_INSERT:
                begin
                    if (flag)
                    begin
                        entry_next = left.flag ? left.entry : op.value;
                    end
                    valid_next = valid_reg | left.valid;
                    curs_next  = op.empty ? 1'b1 : left.flag;
                end
                slc_pkg::KIND_REMOVE:
                begin
                    if (curs_reg)
                    begin
                        entry_next = right.entry;
                    end
                    valid_next = right.valid;
                end
                slc_pkg::KIND_ADVANCE: curs_next = left.curs;
                slc_pkg::KIND_RETREAT: curs_next = right.curs;
                slc_pkg::KIND_FIRST:   curs_next = 1'b1;
                slc_pkg::KIND_LAST:    curs_next = !right.valid;
                slc_pkg::KIND_CLEAR:
                begin
                    valid_next = 1'b0;
                    curs_next  = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            curs_reg  <= 1'b1;
        end
        else
        begin
            valid_reg <= valid_next;
            curs_reg  <= curs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign self.entry = entry_reg;
    assign self.valid = valid_reg;
    assign self.flag  = flag;
    assign self.curs  = curs_reg;

endmodule

FILE: hw/rtl/sorted_list_with_cursor.sv
// Sorted list with cursor: a row of DEPTH cells plus head marker and readout.
// The cell row updates on the accepting beat; the cursor readout is then registered into the
// output registers once they are free, and out_ready can stall this. in_ready stays low until that
// load, so one operation's row update and its cursor readout (one-hot select over all cells) do not overlap the next.
// Reset: list empty, cursor on the tail marker; entries are not cleared.
// Depends on slc_pkg and slc_cell.
module sorted_list_with_cursor #(
    parameter int DEPTH = slc_pkg::DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0]                           kind,
    input  logic signed [slc_pkg::VAL_W-1:0]     value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [slc_pkg::VAL_W-1:0]     cursor_value,
    output logic [2:0]                           status,
    output logic                                 at_head,
    output logic                                 at_tail,
    output logic [slc_pkg::CNT_OUT_W-1:0]        entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    slc_pkg::nbr_t   cells [DEPTH];
    slc_pkg::op_t    op;
    slc_pkg::kind_t  kind_in;
    slc_pkg::status_t st;

    logic             acc;
    logic             head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             calc_reg;
    logic             on_entry_reg;
    logic             at_tail_reg;
    slc_pkg::status_t st_reg;

    logic                             out_valid_reg;
    logic signed [slc_pkg::VAL_W-1:0] cval_reg;
    slc_pkg::status_t                 out_st_reg;
    logic                             out_head_reg;
    logic                             out_tail_reg;
    logic [CNT_W-1:0]                 out_cnt_reg;

    logic                             load;
    logic [DEPTH-1:0]                 hit;
    logic                             on_entry;
    logic signed [slc_pkg::VAL_W-1:0] sel_val;

    slc_pkg::nbr_t left_edge;
    slc_pkg::nbr_t right_edge;

    assign kind_in  = slc_pkg::kind_t'(kind);
    assign in_ready = !calc_reg;
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        st = slc_pkg::ST_OK;
        case (kind_in)
            slc_pkg::KIND_READ:    if (!on_entry_reg) st = slc_pkg::ST_MARKER;
            slc_pkg::KIND_INSERT:  if (cells[DEPTH-1].valid) st = slc_pkg::ST_FULL;
            slc_pkg::KIND_REMOVE:  if (!on_entry_reg) st = slc_pkg::ST_MARKER;
            slc_pkg::KIND_ADVANCE: if (at_tail_reg) st = slc_pkg::ST_NO_ADVANCE;
            slc_pkg::KIND_RETREAT: if (head_reg) st = slc_pkg::ST_NO_RETREAT;
            default: ;
        endcase
    end

    assign op.apply = acc && (st == slc_pkg::ST_OK);
    assign op.kind  = kind_in;
    assign op.value = value;
    assign op.empty = !cells[0].valid;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (op.apply)
        begin
            case (kind_in)
                slc_pkg::KIND_INSERT:
                begin
                    head_next  = op.empty;
                    count_next = count_reg + CNT_W'(1);
                end
                slc_pkg::KIND_REMOVE:  count_next = count_reg - CNT_W'(1);
                slc_pkg::KIND_ADVANCE: head_next = 1'b0;
                slc_pkg::KIND_RETREAT: head_next = cells[0].curs;
                slc_pkg::KIND_FIRST:   head_next = 1'b0;
                slc_pkg::KIND_LAST:    head_next = op.empty;
                slc_pkg::KIND_CLEAR:
                begin
                    head_next  = 1'b0;
                    count_next = '0;
                end
                default: ;
            endcase
        end
    end

    assign left_edge.entry  = '0;
    assign left_edge.valid  = 1'b1;
    assign left_edge.flag   = 1'b0;
    assign left_edge.curs   = head_reg;
    assign right_edge.entry = '0;
    assign right_edge.valid = 1'b0;
    assign right_edge.flag  = 1'b1;
    assign right_edge.curs  = 1'b1;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        slc_pkg::nbr_t l_nbr;
        slc_pkg::nbr_t r_nbr;
        if (i == 0)
        begin : g_first
            assign l_nbr = left_edge;
        end
        else
        begin : g_mid_l
            assign l_nbr = cells[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign r_nbr = right_edge;
        end
        else
        begin : g_mid_r
            assign r_nbr = cells[i+1];
        end
        slc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .op    (op),
            .left  (l_nbr),
            .right (r_nbr),
            .self  (cells[i])
        );
        assign hit[i] = cells[i].curs && !l_nbr.curs && cells[i].valid;
    end

    // cursor readout: one-hot select over the row
    always_comb
    begin
        sel_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_val = sel_val | (cells[i].entry & {slc_pkg::VAL_W{hit[i]}});
        end
    end

    assign on_entry = |hit;
    assign load     = calc_reg && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= 1'b0;
            count_reg     <= '0;
            calc_reg      <= 1'b0;
            on_entry_reg  <= 1'b0;
            at_tail_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (acc)
            begin
                calc_reg <= 1'b1;
            end
            else if (load)
            begin
                calc_reg <= 1'b0;
            end
            if (load)
            begin
                on_entry_reg  <= on_entry;
                at_tail_reg   <= !head_reg && !on_entry;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            st_reg <= st;
        end
        if (load)
        begin
            cval_reg     <= on_entry ? sel_val : -32'sd1;
            out_st_reg   <= st_reg;
            out_head_reg <= head_reg;
            out_tail_reg <= !head_reg && !on_entry;
            out_cnt_reg  <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cursor_value = cval_reg;
    assign status       = out_st_reg;
    assign at_head      = out_head_reg;
    assign at_tail      = out_tail_reg;
    assign entry_count  = slc_pkg::CNT_OUT_W'(out_cnt_reg);

endmodule
